// ===== design/modrtu_pkg.sv =====
package modrtu_pkg;

    // Frame store depth default and the largest register count of one read frame.
    localparam int FRAME_BYTES_MAX_DEF = 21;
    localparam int FEEDBACK_REGS       = 8;

    // Field widths fixed by the payload.
    localparam int BYTE_W    = 8;
    localparam int COUNT_W   = 5;
    localparam int REG_IDX_W = 3;
    localparam int NREG_W    = 4;
    localparam int CNT_W     = 32;

    // Modbus function codes.
    localparam logic [BYTE_W-1:0] FN_WRITE_SINGLE = 8'h06;
    localparam logic [BYTE_W-1:0] FN_WRITE_MULTI  = 8'h10;
    localparam logic [BYTE_W-1:0] FN_READ_HOLDING = 8'h03;

    // Frame layout: address, function, byte count, data, CRC low, CRC high.
    localparam int POS_FUNC      = 1;
    localparam int POS_COUNT     = 2;
    localparam int DATA_START    = 3;
    localparam int ACK_LEN       = 8;
    localparam int READ_OVERHEAD = 5;

    // CRC-16 constants.
    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    // Register reset values.
    localparam logic [BYTE_W-1:0]  SLAVE_ADDR_RST = 8'h0A;
    localparam logic [COUNT_W-1:0] READ_COUNT_RST = 5'd16;

    // Configuration register indexes.
    typedef enum logic [0:0] {
        CFG_SLAVE_ADDR = 1'b0,
        CFG_READ_COUNT = 1'b1
    } t_cfg_idx;

    // Result event codes.
    typedef enum logic [2:0] {
        EV_NONE     = 3'd0,
        EV_FEEDBACK = 3'd1,
        EV_ACK      = 3'd2,
        EV_CRC_ERR  = 3'd3,
        EV_LINE_ERR = 3'd4
    } t_event;

    // Frame controller states.
    typedef enum logic [1:0] {
        FC_IDLE,
        FC_RD_HI,
        FC_RD_LO,
        FC_EMIT
    } t_fc_state;

    typedef struct packed {
        logic              action;
        logic [BYTE_W-1:0] rx_byte;
    } t_in_item;

    // One result as the frame controller hands it over.
    typedef struct packed {
        t_event                event_res;
        logic [REG_IDX_W-1:0]  reg_index;
        logic signed [15:0]    reg_value;
        logic                  last;
    } t_res;

    typedef struct packed {
        t_event                event_res;
        logic [REG_IDX_W-1:0]  reg_index;
        logic signed [15:0]    reg_value;
        logic                  last;
        logic [CNT_W-1:0]      feedback_frames;
        logic [CNT_W-1:0]      ack_frames;
        logic [CNT_W-1:0]      crc_errors;
        logic [CNT_W-1:0]      line_errors;
    } t_out_item;

    // Counter increment requests.
    typedef struct packed {
        logic feedback;
        logic ack;
        logic crc_err;
        logic line_err;
    } t_cnt_bump;

    // One byte through the reflected CRC-16, bit by bit.
    function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

// ===== design/modbus_rtu_response_parser_core.sv =====
// Modbus RTU response parser. Bytes from the UART (or line-error events) come in
// on the input channel; results go out on the output channel, each carrying the
// four wrapping frame counters as they stand after the input that caused it.
// An ordinary byte is taken while the block is idle and the output register can
// take a result, and a byte that ends a write acknowledgement or a frame that
// fails its CRC check gives its single result to the output register in that same
// cycle. A good read frame then plays back its registers from the frame store,
// one register at a time (high-byte read, low-byte read, transfer, which waits on
// the output register), and holds the input until the last one is transferred;
// the frame store has a single read port. It needs no clearing after reset.
// Configuration writes are always taken and must only be issued while the block is idle.
module modbus_rtu_response_parser_core #(
    parameter int FRAME_BYTES_MAX = modrtu_pkg::FRAME_BYTES_MAX_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  modrtu_pkg::t_in_item               i_in_item,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output modrtu_pkg::t_out_item              o_out_item,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  modrtu_pkg::t_cfg_idx               i_cfg_index,
    input  logic [modrtu_pkg::BYTE_W-1:0]      i_cfg_data
);

    logic [modrtu_pkg::BYTE_W-1:0]  r_slave_addr;
    logic [modrtu_pkg::COUNT_W-1:0] r_read_count;
    logic                           r_out_valid;
    modrtu_pkg::t_res               r_res;

    logic                           in_ready;
    logic                           res_valid;
    logic                           res_ready;
    modrtu_pkg::t_res               res;
    modrtu_pkg::t_cnt_bump          bump;
    logic [modrtu_pkg::CNT_W-1:0]   cnt_feedback;
    logic [modrtu_pkg::CNT_W-1:0]   cnt_ack;
    logic [modrtu_pkg::CNT_W-1:0]   cnt_crc_err;
    logic [modrtu_pkg::CNT_W-1:0]   cnt_line_err;

    // Configuration registers.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slave_addr <= modrtu_pkg::SLAVE_ADDR_RST;
            r_read_count <= modrtu_pkg::READ_COUNT_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                modrtu_pkg::CFG_SLAVE_ADDR: r_slave_addr <= i_cfg_data;
                modrtu_pkg::CFG_READ_COUNT: r_read_count <= i_cfg_data[modrtu_pkg::COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    modrtu_frame_ctl #(
        .FRAME_BYTES_MAX (FRAME_BYTES_MAX)
    ) u_frame_ctl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_item    (i_in_item),
        .o_in_ready   (in_ready),
        .i_slave_addr (r_slave_addr),
        .i_read_count (r_read_count),
        .o_res_valid  (res_valid),
        .o_res        (res),
        .i_res_ready  (res_ready),
        .o_bump       (bump)
    );

    modrtu_stat_cnt u_stat_cnt (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_bump            (bump),
        .o_feedback_frames (cnt_feedback),
        .o_ack_frames      (cnt_ack),
        .o_crc_errors      (cnt_crc_err),
        .o_line_errors     (cnt_line_err)
    );

    // Output register: refills whenever it is empty or its transfer completes.
    assign res_ready  = !r_out_valid || !i_out_stall;
    assign o_in_stall = !in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_ready) begin
            r_out_valid <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_ready && res_valid) begin
            r_res <= res;
        end
    end

    // Counters only move when an input is taken, which never happens while a
    // result is held, so they ride along with the registered result.
    assign o_out_valid                = r_out_valid;
    assign o_out_item.event_res       = r_res.event_res;
    assign o_out_item.reg_index       = r_res.reg_index;
    assign o_out_item.reg_value       = r_res.reg_value;
    assign o_out_item.last            = r_res.last;
    assign o_out_item.feedback_frames = cnt_feedback;
    assign o_out_item.ack_frames      = cnt_ack;
    assign o_out_item.crc_errors      = cnt_crc_err;
    assign o_out_item.line_errors     = cnt_line_err;

endmodule

// ===== design/modrtu_stat_cnt.sv =====
module modrtu_stat_cnt (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  modrtu_pkg::t_cnt_bump              i_bump,
    output logic [modrtu_pkg::CNT_W-1:0]       o_feedback_frames,
    output logic [modrtu_pkg::CNT_W-1:0]       o_ack_frames,
    output logic [modrtu_pkg::CNT_W-1:0]       o_crc_errors,
    output logic [modrtu_pkg::CNT_W-1:0]       o_line_errors
);

    logic [modrtu_pkg::CNT_W-1:0] r_feedback;
    logic [modrtu_pkg::CNT_W-1:0] r_ack;
    logic [modrtu_pkg::CNT_W-1:0] r_crc_err;
    logic [modrtu_pkg::CNT_W-1:0] r_line_err;

    // Four wrapping event counters.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_feedback <= '0;
            r_ack      <= '0;
            r_crc_err  <= '0;
            r_line_err <= '0;
        end else begin
            if (i_bump.feedback) begin
                r_feedback <= r_feedback + 1'b1;
            end
            if (i_bump.ack) begin
                r_ack <= r_ack + 1'b1;
            end
            if (i_bump.crc_err) begin
                r_crc_err <= r_crc_err + 1'b1;
            end
            if (i_bump.line_err) begin
                r_line_err <= r_line_err + 1'b1;
            end
        end
    end

    assign o_feedback_frames = r_feedback;
    assign o_ack_frames      = r_ack;
    assign o_crc_errors      = r_crc_err;
    assign o_line_errors     = r_line_err;

endmodule

// ===== design/modrtu_frame_ctl.sv =====
module modrtu_frame_ctl #(
    parameter int FRAME_BYTES_MAX = modrtu_pkg::FRAME_BYTES_MAX_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    input  modrtu_pkg::t_in_item                 i_in_item,
    output logic                                 o_in_ready,
    input  logic [modrtu_pkg::BYTE_W-1:0]        i_slave_addr,
    input  logic [modrtu_pkg::COUNT_W-1:0]       i_read_count,
    output logic                                 o_res_valid,
    output modrtu_pkg::t_res                     o_res,
    input  logic                                 i_res_ready,
    output modrtu_pkg::t_cnt_bump                o_bump
);

    localparam int IW = $clog2(FRAME_BYTES_MAX + 1);
    localparam int AW = $clog2(FRAME_BYTES_MAX);

    modrtu_pkg::t_fc_state r_state, n_state;

    logic [IW-1:0]                        r_idx, n_idx;
    logic [IW-1:0]                        r_exp, n_exp;
    logic [15:0]                          r_crc, n_crc;
    logic [modrtu_pkg::BYTE_W-1:0]        r_fn, n_fn;
    logic [modrtu_pkg::BYTE_W-1:0]        r_prev, n_prev;
    logic [modrtu_pkg::NREG_W-1:0]        r_nreg, n_nreg;
    logic [modrtu_pkg::REG_IDX_W-1:0]     r_ri, n_ri;
    logic [modrtu_pkg::BYTE_W-1:0]        r_hi, n_hi;

    // Frame store and its registered read port.
    logic [modrtu_pkg::BYTE_W-1:0]        r_frame_mem [FRAME_BYTES_MAX];
    logic [modrtu_pkg::BYTE_W-1:0]        r_rd_data;
    logic                                 mem_we;
    logic [AW-1:0]                        mem_wa;
    logic                                 mem_re;
    logic [AW-1:0]                        mem_ra;

    logic [modrtu_pkg::BYTE_W-1:0]        w_byte;
    logic [IW-1:0]                        w_idx_inc;
    logic                                 w_crc_on;
    logic [15:0]                          w_crc_new;
    logic                                 w_too_long;
    logic [IW-1:0]                        w_exp;
    logic                                 w_drop;
    logic [IW:0]                          w_hi_addr;
    logic [IW:0]                          w_lo_addr;
    logic                                 w_last;

    assign w_byte    = i_in_item.rx_byte;
    assign w_idx_inc = r_idx + 1'b1;

    // The CRC runs over every byte until the frame length is known, then stops
    // short of the two CRC bytes.
    assign w_crc_on  = (r_exp == '0) || (({1'b0, r_idx} + (IW+1)'(2)) < {1'b0, r_exp});
    assign w_crc_new = w_crc_on ? modrtu_pkg::crc_feed(r_crc, w_byte) : r_crc;

    assign w_too_long = ({1'b0, w_byte} + 9'(modrtu_pkg::READ_OVERHEAD))
                        > 9'(FRAME_BYTES_MAX);

    // Register readback addresses: high byte first in the frame.
    assign w_hi_addr = (IW+1)'(modrtu_pkg::DATA_START) + (IW+1)'({r_ri, 1'b0});
    assign w_lo_addr = w_hi_addr + 1'b1;
    assign w_last    = (({1'b0, r_ri} + modrtu_pkg::NREG_W'(1)) == r_nreg);

    // Frame store: one write port from the byte path, one read port for readback.
    // Readback starts only after the frame's last byte is written, so the two
    // ports never touch the same entry in one cycle.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_frame_mem[mem_wa] <= w_byte;
        end
        if (mem_re) begin
            r_rd_data <= r_frame_mem[mem_ra];
        end
    end

    // State and frame registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= modrtu_pkg::FC_IDLE;
            r_idx   <= '0;
            r_exp   <= '0;
            r_crc   <= modrtu_pkg::CRC_INIT;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_exp   <= n_exp;
            r_crc   <= n_crc;
        end
    end

    always_ff @(posedge i_clk) begin
        r_fn   <= n_fn;
        r_prev <= n_prev;
        r_nreg <= n_nreg;
        r_ri   <= n_ri;
        r_hi   <= n_hi;
    end

    // Byte framing, frame check and register readback sequencing.
    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_exp       = r_exp;
        n_crc       = r_crc;
        n_fn        = r_fn;
        n_prev      = r_prev;
        n_nreg      = r_nreg;
        n_ri        = r_ri;
        n_hi        = r_hi;
        mem_we      = 1'b0;
        mem_wa      = r_idx[AW-1:0];
        mem_re      = 1'b0;
        mem_ra      = w_hi_addr[AW-1:0];
        w_exp       = r_exp;
        w_drop      = 1'b0;
        o_in_ready  = 1'b0;
        o_res_valid = 1'b0;
        o_res       = '0;
        o_bump      = '0;

        unique case (r_state)
            modrtu_pkg::FC_IDLE: begin
                o_in_ready = i_res_ready;
                if (i_in_valid && i_res_ready) begin
                    if (i_in_item.action) begin
                        // Line error: report, count and restart the hunt.
                        n_idx             = '0;
                        n_exp             = '0;
                        n_crc             = modrtu_pkg::CRC_INIT;
                        o_bump.line_err   = 1'b1;
                        o_res_valid       = 1'b1;
                        o_res.event_res   = modrtu_pkg::EV_LINE_ERR;
                        o_res.last        = 1'b1;
                    end else if (r_idx == '0) begin
                        // Hunting for the slave address.
                        if (w_byte == i_slave_addr) begin
                            mem_we = 1'b1;
                            mem_wa = '0;
                            n_crc  = modrtu_pkg::crc_feed(modrtu_pkg::CRC_INIT, w_byte);
                            n_idx  = IW'(1);
                        end
                    end else if (r_idx >= IW'(FRAME_BYTES_MAX)) begin
                        n_idx = '0;
                        n_exp = '0;
                        n_crc = modrtu_pkg::CRC_INIT;
                    end else begin
                        mem_we = 1'b1;
                        n_idx  = w_idx_inc;
                        n_prev = w_byte;
                        n_crc  = w_crc_new;
                        if (r_idx == IW'(modrtu_pkg::POS_FUNC)) begin
                            n_fn = w_byte;
                            if (w_byte == modrtu_pkg::FN_WRITE_SINGLE ||
                                w_byte == modrtu_pkg::FN_WRITE_MULTI) begin
                                w_exp = IW'(modrtu_pkg::ACK_LEN);
                            end else if (w_byte != modrtu_pkg::FN_READ_HOLDING) begin
                                w_drop = 1'b1;
                            end
                        end else if (r_idx == IW'(modrtu_pkg::POS_COUNT) &&
                                     r_fn == modrtu_pkg::FN_READ_HOLDING) begin
                            if (w_byte != {3'b000, i_read_count} || w_too_long) begin
                                w_drop = 1'b1;
                            end else begin
                                w_exp  = IW'(w_byte) + IW'(modrtu_pkg::READ_OVERHEAD);
                                n_nreg = w_byte[modrtu_pkg::NREG_W:1];
                            end
                        end
                        n_exp = w_exp;

                        if (w_drop) begin
                            n_idx = '0;
                            n_exp = '0;
                            n_crc = modrtu_pkg::CRC_INIT;
                        end else if (w_exp != '0 && w_idx_inc >= w_exp) begin
                            // Frame end: CRC arrives low byte first.
                            n_idx = '0;
                            n_exp = '0;
                            n_crc = modrtu_pkg::CRC_INIT;
                            if ({w_byte, r_prev} != w_crc_new) begin
                                o_bump.crc_err  = 1'b1;
                                o_res_valid     = 1'b1;
                                o_res.event_res = modrtu_pkg::EV_CRC_ERR;
                                o_res.last      = 1'b1;
                            end else if (r_fn != modrtu_pkg::FN_READ_HOLDING) begin
                                o_bump.ack      = 1'b1;
                                o_res_valid     = 1'b1;
                                o_res.event_res = modrtu_pkg::EV_ACK;
                                o_res.last      = 1'b1;
                            end else if (r_nreg != '0 &&
                                         r_nreg <= modrtu_pkg::NREG_W'(modrtu_pkg::FEEDBACK_REGS))
                            begin
                                o_bump.feedback = 1'b1;
                                n_ri            = '0;
                                n_state         = modrtu_pkg::FC_RD_HI;
                            end
                        end
                    end
                end
            end
            modrtu_pkg::FC_RD_HI: begin
                mem_re  = 1'b1;
                mem_ra  = w_hi_addr[AW-1:0];
                n_state = modrtu_pkg::FC_RD_LO;
            end
            modrtu_pkg::FC_RD_LO: begin
                mem_re  = 1'b1;
                mem_ra  = w_lo_addr[AW-1:0];
                n_hi    = r_rd_data;
                n_state = modrtu_pkg::FC_EMIT;
            end
            modrtu_pkg::FC_EMIT: begin
                o_res_valid     = 1'b1;
                o_res.event_res = modrtu_pkg::EV_FEEDBACK;
                o_res.reg_index = r_ri;
                o_res.reg_value = $signed({r_hi, r_rd_data});
                o_res.last      = w_last;
                if (i_res_ready) begin
                    if (w_last) begin
                        n_state = modrtu_pkg::FC_IDLE;
                    end else begin
                        n_ri    = r_ri + 1'b1;
                        n_state = modrtu_pkg::FC_RD_HI;
                    end
                end
            end
            default: begin
                n_state = modrtu_pkg::FC_IDLE;
            end
        endcase
    end

endmodule

// ===== design/modrtu_checker.sv =====
module modrtu_checker (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_in_valid,
    input logic                   o_in_stall,
    input modrtu_pkg::t_in_item   i_in_item,
    input logic                   o_out_valid,
    input logic                   i_out_stall,
    input modrtu_pkg::t_out_item  o_out_item
);

    logic in_xfer;
    assign in_xfer = i_in_valid && !o_in_stall;

    // A stalled result holds, counters included.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_item))
        else $error("stalled result changed");

    // A line error gives one final result and bumps its counter by one.
    a_line_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rst_n && in_xfer && i_in_item.action |=>
            o_out_valid && o_out_item.event_res == modrtu_pkg::EV_LINE_ERR &&
            o_out_item.last &&
            o_out_item.line_errors == $past(o_out_item.line_errors) + 1'b1)
        else $error("line error not reported");

    // A received byte never touches the line error counter.
    a_byte_no_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rst_n && in_xfer && !i_in_item.action |=>
            o_out_item.line_errors == $past(o_out_item.line_errors))
        else $error("line error count moved on a byte");

    // Only register results carry an index or value, and the others end their input.
    a_non_reg_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.event_res != modrtu_pkg::EV_FEEDBACK |->
            o_out_item.reg_index == '0 && o_out_item.reg_value == '0 && o_out_item.last)
        else $error("bad fields on non-register result");

endmodule

bind modbus_rtu_response_parser_core modrtu_checker u_modrtu_checker (.*);

// ===== dv/modbus_rtu_response_checker.sv =====
// Watches the byte, result and configuration channels of the response parser.
// It keeps its own copy of the framing state and predicts the results that each
// accepted byte or line-error event should give. Every result transfer is
// compared field by field against the oldest prediction.
module modbus_rtu_response_checker
    import modrtu_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  t_in_item    i_in_item,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  t_out_item   i_out_item,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  t_cfg_idx    i_cfg_index,
    input  logic [7:0]  i_cfg_data,
    output int          o_fail_count,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAME_DEPTH = FRAME_BYTES_MAX_DEF;

    // Shadow of the framing state.
    logic [7:0]         frame_bytes [FRAME_DEPTH];
    int                 byte_pos;
    int                 frame_len;
    logic [15:0]        crc_acc;
    logic [CNT_W-1:0]   n_feedback;
    logic [CNT_W-1:0]   n_ack;
    logic [CNT_W-1:0]   n_crc_err;
    logic [CNT_W-1:0]   n_line_err;
    logic [7:0]         match_addr;
    logic [COUNT_W-1:0] match_count;

    // Predicted results, oldest first.
    t_out_item          expected_results [$];
    int                 fails = 0;

    // Reflected CRC-16 over one byte, least significant bit first.
    function automatic logic [15:0] crc16_shift_byte(logic [15:0] crc, logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        repeat (8) c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        return c;
    endfunction

    function automatic void restart_hunt();
        byte_pos  = 0;
        frame_len = 0;
        crc_acc   = CRC_INIT;
    endfunction

    // Queue one result; the counters are taken as they stand now.
    function automatic void expect_result(t_event ev, logic [2:0] idx, logic [15:0] val,
                                          logic last);
        t_out_item r;
        r.event_res       = ev;
        r.reg_index       = idx;
        r.reg_value       = val;
        r.last            = last;
        r.feedback_frames = n_feedback;
        r.ack_frames      = n_ack;
        r.crc_errors      = n_crc_err;
        r.line_errors     = n_line_err;
        expected_results.push_back(r);
    endfunction

    // Advance the framing state by one accepted transfer and queue its results.
    function automatic void predict_rx(t_in_item it);
        logic [7:0]  b;
        logic [7:0]  fn;
        logic [15:0] got_crc;
        logic [15:0] calc_crc;
        int          pos;
        int          n_regs;

        if (it.action) begin
            n_line_err++;
            restart_hunt();
            expect_result(EV_LINE_ERR, '0, '0, 1'b1);
            return;
        end
        b = it.rx_byte;

        // Hunting for the slave address; other bytes are dropped.
        if (byte_pos == 0) begin
            if (b == match_addr) begin
                frame_bytes[0] = b;
                crc_acc        = crc16_shift_byte(CRC_INIT, b);
                byte_pos       = 1;
            end
            return;
        end
        if (byte_pos >= FRAME_DEPTH) begin
            restart_hunt();
            return;
        end

        // Store the byte; the two CRC bytes stay out of the running CRC.
        pos              = byte_pos;
        frame_bytes[pos] = b;
        byte_pos         = pos + 1;
        if (frame_len == 0 || pos + 2 < frame_len) begin
            crc_acc = crc16_shift_byte(crc_acc, b);
        end

        // The function code and the byte count decide the frame length.
        if (byte_pos == 2) begin
            if (b == FN_WRITE_SINGLE || b == FN_WRITE_MULTI) begin
                frame_len = ACK_LEN;
            end else if (b != FN_READ_HOLDING) begin
                restart_hunt();
                return;
            end
        end else if (byte_pos == 3 && frame_bytes[POS_FUNC] == FN_READ_HOLDING) begin
            if (b != {3'b000, match_count} || int'(b) + READ_OVERHEAD > FRAME_DEPTH) begin
                restart_hunt();
                return;
            end
            frame_len = int'(b) + READ_OVERHEAD;
        end

        // Frame complete: check the CRC, then report.
        if (frame_len != 0 && byte_pos >= frame_len) begin
            got_crc  = {frame_bytes[frame_len-1], frame_bytes[frame_len-2]};
            calc_crc = crc_acc;
            fn       = frame_bytes[POS_FUNC];
            n_regs   = int'(frame_bytes[POS_COUNT]) / 2;
            restart_hunt();
            if (got_crc != calc_crc) begin
                n_crc_err++;
                expect_result(EV_CRC_ERR, '0, '0, 1'b1);
            end else if (fn != FN_READ_HOLDING) begin
                n_ack++;
                expect_result(EV_ACK, '0, '0, 1'b1);
            end else if (n_regs >= 1 && n_regs <= FEEDBACK_REGS) begin
                n_feedback++;
                for (int i = 0; i < n_regs; i++) begin
                    expect_result(EV_FEEDBACK, 3'(i),
                                  {frame_bytes[DATA_START+2*i], frame_bytes[DATA_START+2*i+1]},
                                  (i + 1 == n_regs));
                end
            end
        end
    endfunction

    // Returns 1 and reports when a field differs from its prediction.
    function automatic int field_mismatch(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
            return 1;
        end
        return 0;
    endfunction

    always @(posedge i_clk) begin : monitor
        t_out_item want;
        int        errs;
        if (!i_rst_n) begin
            restart_hunt();
            n_feedback  = '0;
            n_ack       = '0;
            n_crc_err   = '0;
            n_line_err  = '0;
            match_addr  = SLAVE_ADDR_RST;
            match_count = READ_COUNT_RST;
            expected_results.delete();
        end else begin
            // Register writes.
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_SLAVE_ADDR: match_addr  = i_cfg_data;
                    CFG_READ_COUNT: match_count = i_cfg_data[COUNT_W-1:0];
                endcase
            end
            // Input transfers are predicted before the result of this edge is checked.
            if (i_in_valid && !i_in_stall) begin
                predict_rx(i_in_item);
            end
            // Result transfers.
            if (i_out_valid && !i_out_stall) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: result transfer with no prediction waiting, actual 0x%0h",
                             $time, i_out_item);
                    fails++;
                end else begin
                    want = expected_results.pop_front();
                    errs = 0;
                    errs += field_mismatch("event_res", 32'(want.event_res),
                                           32'(i_out_item.event_res));
                    errs += field_mismatch("reg_index", 32'(want.reg_index),
                                           32'(i_out_item.reg_index));
                    errs += field_mismatch("reg_value", 32'(want.reg_value),
                                           32'(i_out_item.reg_value));
                    errs += field_mismatch("last", 32'(want.last), 32'(i_out_item.last));
                    errs += field_mismatch("feedback_frames", want.feedback_frames,
                                           i_out_item.feedback_frames);
                    errs += field_mismatch("ack_frames", want.ack_frames, i_out_item.ack_frames);
                    errs += field_mismatch("crc_errors", want.crc_errors, i_out_item.crc_errors);
                    errs += field_mismatch("line_errors", want.line_errors,
                                           i_out_item.line_errors);
                    if (errs != 0) begin
                        fails++;
                    end
                end
            end
        end
        o_pending    <= expected_results.size();
        o_fail_count <= fails;
    end

endmodule

// ===== dv/tb_modbus_rtu_response_parser_core.sv =====
// Drives Modbus response byte streams into the parser and gives the verdict.
// The checker beside the block does all prediction and comparison.
module tb_modbus_rtu_response_parser_core;
    timeunit 1ns;
    timeprecision 1ps;

    import modrtu_pkg::*;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 40;
    localparam int HOLD_CYCLES   = 400;
    localparam int PHASE_ITEMS   = 75;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_in_valid;
    logic       o_in_stall;
    t_in_item   i_in_item;
    logic       o_out_valid;
    logic       i_out_stall;
    t_out_item  o_out_item;
    logic       i_cfg_valid;
    logic       o_cfg_ready;
    t_cfg_idx   i_cfg_index;
    logic [7:0] i_cfg_data;

    int fail_count;
    int pending;

    // Idling odds in percent, and the request for a long receiver hold-off.
    int send_idle_pct = 0;
    int stall_pct     = 0;
    bit hold_req      = 1'b0;

    // Register values currently programmed, used to build frames.
    logic [7:0]         cur_addr;
    logic [COUNT_W-1:0] cur_count;

    // Bytes of the frame being built.
    logic [7:0] tx_frame [$];
    int         phase_items;

    modbus_rtu_response_parser_core DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    modbus_rtu_response_checker u_response_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_stall   (o_in_stall),
        .i_in_item    (i_in_item),
        .i_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .i_out_item   (o_out_item),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Offer one item, with random idle cycles ahead of it, and hold it until the transfer.
    task automatic send_item(input logic action, input logic [7:0] data);
        @(negedge i_clk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid        = 1'b1;
        i_in_item.action  = action;
        i_in_item.rx_byte = data;
        do @(posedge i_clk); while (o_in_stall);
        phase_items++;
    endtask

    task automatic send_line_error();
        send_item(1'b1, 8'($urandom));
    endtask

    task automatic send_frame();
        foreach (tx_frame[k]) send_item(1'b0, tx_frame[k]);
    endtask

    // Stop sending and wait until every predicted result has been transferred.
    task automatic wait_drained();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [7:0] data);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = data;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic configure(input logic [7:0] addr, input logic [COUNT_W-1:0] cnt);
        write_reg(CFG_SLAVE_ADDR, addr);
        write_reg(CFG_READ_COUNT, {3'b000, cnt});
        cur_addr  = addr;
        cur_count = cnt;
    endtask

    // Reflected CRC-16 over the whole frame built so far.
    function automatic logic [15:0] frame_crc16();
        logic [15:0] c;
        c = CRC_INIT;
        foreach (tx_frame[k]) begin
            c ^= {8'h00, tx_frame[k]};
            for (int j = 0; j < 8; j++) begin
                c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
            end
        end
        return c;
    endfunction

    // Data bytes lean toward the extremes of a 16-bit register.
    function automatic logic [7:0] pick_data_byte();
        case ($urandom_range(0, 7))
            0:       return 8'h00;
            1:       return 8'hFF;
            2:       return 8'h7F;
            3:       return 8'h80;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic void start_frame(input logic [7:0] fn);
        tx_frame.delete();
        tx_frame.push_back(cur_addr);
        tx_frame.push_back(fn);
    endfunction

    // Append the CRC low byte first, optionally with one bit flipped.
    function automatic void seal_frame(input bit corrupt);
        logic [15:0] crc;
        crc = frame_crc16();
        if (corrupt) begin
            crc ^= 16'(1) << $urandom_range(0, 15);
        end
        tx_frame.push_back(crc[7:0]);
        tx_frame.push_back(crc[15:8]);
    endfunction

    function automatic void build_read(input logic [7:0] cnt, input bit corrupt);
        start_frame(FN_READ_HOLDING);
        tx_frame.push_back(cnt);
        repeat (cnt) tx_frame.push_back(pick_data_byte());
        seal_frame(corrupt);
    endfunction

    function automatic void build_ack(input logic [7:0] fn, input bit corrupt);
        start_frame(fn);
        repeat (4) tx_frame.push_back(8'($urandom));
        seal_frame(corrupt);
    endfunction

    function automatic logic [7:0] pick_write_fn();
        return $urandom_range(0, 1) ? FN_WRITE_MULTI : FN_WRITE_SINGLE;
    endfunction

    // One random sequence: mostly well-formed frames, the rest broken frames and noise.
    task automatic send_random_sequence();
        int         pick;
        int         cut;
        logic [7:0] b;
        pick = $urandom_range(0, 99);
        if (pick < 40) begin
            build_read({3'b000, cur_count}, 1'b0);
            send_frame();
        end else if (pick < 55) begin
            build_ack(pick_write_fn(), 1'b0);
            send_frame();
        end else if (pick < 65) begin
            if ($urandom_range(0, 1)) begin
                build_read({3'b000, cur_count}, 1'b1);
            end else begin
                build_ack(pick_write_fn(), 1'b1);
            end
            send_frame();
        end else if (pick < 70) begin
            // Read response whose byte count does not match the register.
            do begin
                b = $urandom_range(0, 1) ? 8'($urandom_range(0, 31)) : 8'($urandom);
            end while (b == {3'b000, cur_count});
            start_frame(FN_READ_HOLDING);
            tx_frame.push_back(b);
            repeat ($urandom_range(0, 4)) tx_frame.push_back(8'($urandom));
            send_frame();
        end else if (pick < 75) begin
            // Unknown function code.
            do b = 8'($urandom);
            while (b == FN_READ_HOLDING || b == FN_WRITE_SINGLE || b == FN_WRITE_MULTI);
            start_frame(b);
            repeat ($urandom_range(0, 3)) tx_frame.push_back(8'($urandom));
            send_frame();
        end else if (pick < 82) begin
            send_line_error();
        end else if (pick < 90) begin
            // Frame cut short by a line error.
            if ($urandom_range(0, 1)) begin
                build_read({3'b000, cur_count}, 1'b0);
            end else begin
                build_ack(pick_write_fn(), 1'b0);
            end
            cut = $urandom_range(1, tx_frame.size() - 1);
            for (int k = 0; k < cut; k++) send_item(1'b0, tx_frame[k]);
            send_line_error();
        end else begin
            // Line noise, sometimes looking like an address.
            repeat ($urandom_range(1, 4)) begin
                send_item(1'b0, ($urandom_range(0, 3) == 0) ? cur_addr : 8'($urandom));
            end
            if ($urandom_range(0, 1)) begin
                send_line_error();
            end
        end
    endtask

    // Result side: random stalls, plus one long hold-off on request.
    initial begin : receiver
        bit hold_done;
        hold_done   = 1'b0;
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req && !hold_done) begin
                i_out_stall = 1'b1;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_done = 1'b1;
            end
            i_out_stall = ($urandom_range(0, 99) < stall_pct);
        end
    end

    // Runaway guard.
    initial begin : watchdog
        int cycle_count;
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Test completed with failures");
        $finish;
    end

    initial begin : stimulus
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_item   = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_SLAVE_ADDR;
        i_cfg_data  = '0;
        cur_addr    = SLAVE_ADDR_RST;
        cur_count   = READ_COUNT_RST;
        phase_items = 0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed cases at the reset register values.
        send_line_error();
        send_item(1'b0, ~cur_addr);
        build_ack(FN_WRITE_SINGLE, 1'b0);
        send_frame();
        build_ack(FN_WRITE_MULTI, 1'b1);
        send_frame();
        start_frame(8'h55);
        send_frame();
        start_frame(FN_READ_HOLDING);
        tx_frame.push_back(8'd5);
        send_frame();
        start_frame(FN_READ_HOLDING);
        send_frame();
        send_line_error();

        // Random phases, each with its own register setting and idling pattern.
        for (int phase = 0; phase < 4; phase++) begin
            if (phase > 0) begin
                wait_drained();
            end
            case (phase)
                0: begin
                    send_idle_pct = 0;
                    stall_pct     = 0;
                end
                1: begin
                    configure(8'h00, 5'd2);
                    send_idle_pct = 48;
                    stall_pct     = 0;
                end
                2: begin
                    configure(8'hFF, 5'd7);
                    send_idle_pct = 0;
                    stall_pct     = 48;
                end
                default: begin
                    configure(8'($urandom), 5'd16);
                    send_idle_pct = 10;
                    stall_pct     = 10;
                end
            endcase
            // Long receiver hold-off while full read frames keep arriving.
            if (phase == 0) begin
                hold_req = 1'b1;
                repeat (3) begin
                    build_read({3'b000, cur_count}, 1'b0);
                    send_frame();
                end
            end
            phase_items = 0;
            while (phase_items < PHASE_ITEMS) send_random_sequence();
        end

        wait_drained();
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
design/modrtu_pkg.sv
design/modrtu_stat_cnt.sv
design/modrtu_frame_ctl.sv
design/modbus_rtu_response_parser_core.sv
design/modrtu_checker.sv
dv/modbus_rtu_response_checker.sv
dv/tb_modbus_rtu_response_parser_core.sv
